### sv/tlhd_pkg.sv
// shared types and constants for the touch level hysteresis detector
// used by tlhd_divider and touch_level_hysteresis_detector_unit; no dependencies

package tlhd_pkg;

    // field widths
    localparam int TLHD_TIME_BITS   = 48;
    localparam int TLHD_SAMPLE_BITS = 16;
    localparam int TLHD_LEVEL_BITS  = 10;
    localparam int TLHD_COUNT_BITS  = 32;

    // product of a drop and the full level, and the divide step count
    localparam int TLHD_PROD_BITS   = TLHD_SAMPLE_BITS + TLHD_LEVEL_BITS;
    localparam int TLHD_DIV_STEPS   = TLHD_LEVEL_BITS;
    localparam int TLHD_STEP_BITS   = 4;

    // level thresholds
    localparam logic [TLHD_LEVEL_BITS-1:0] TLHD_LEVEL_ON   = 10'd360;
    localparam logic [TLHD_LEVEL_BITS-1:0] TLHD_LEVEL_OFF  = 10'd220;
    localparam logic [TLHD_LEVEL_BITS-1:0] TLHD_LEVEL_FULL = 10'd1000;
    localparam logic [TLHD_LEVEL_BITS-1:0] TLHD_LEVEL_ZERO = 10'd0;

    // configuration register indexes
    localparam logic [1:0] TLHD_REG_ENABLE   = 2'd0;
    localparam logic [1:0] TLHD_REG_BASELINE = 2'd1;
    localparam logic [1:0] TLHD_REG_SPAN     = 2'd2;
    localparam logic [1:0] TLHD_REG_INTERVAL = 2'd3;

    // request to the shared divider
    typedef struct packed {
        logic                        start;
        logic [TLHD_SAMPLE_BITS-1:0] drop;
        logic [TLHD_SAMPLE_BITS-1:0] span;
    } t_div_req;

    // status back from the shared divider
    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic [TLHD_LEVEL_BITS-1:0] quot;
    } t_div_rsp;

endpackage

### sv/tlhd_divider.sv
// iterative scaler: level = drop * 1000 / span, one quotient bit per cycle
// depends on tlhd_pkg; expects drop < span so the quotient fits in ten bits

module tlhd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlhd_pkg::t_div_req i_req,
    output tlhd_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic [tlhd_pkg::TLHD_STEP_BITS-1:0] r_count;
    logic [tlhd_pkg::TLHD_PROD_BITS-1:0] r_rem;
    logic [tlhd_pkg::TLHD_PROD_BITS-1:0] r_den;
    logic [tlhd_pkg::TLHD_LEVEL_BITS-1:0] r_quot;

    logic                                 w_fit;
    logic                                 w_last;
    logic [tlhd_pkg::TLHD_LEVEL_BITS-1:0] n_quot;
    logic [tlhd_pkg::TLHD_PROD_BITS-1:0]  w_prod;

    // one compare and subtract per step
    assign w_fit  = r_rem >= r_den;
    assign w_last = (r_count == tlhd_pkg::TLHD_STEP_BITS'(1));
    assign n_quot = {r_quot[tlhd_pkg::TLHD_LEVEL_BITS-2:0], w_fit};
    assign w_prod = i_req.drop * tlhd_pkg::TLHD_LEVEL_FULL;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_count <= tlhd_pkg::TLHD_STEP_BITS'(tlhd_pkg::TLHD_DIV_STEPS);
        end else if (r_busy) begin
            r_count <= r_count - 1'b1;
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= w_prod;
            r_den  <= {1'b0, i_req.span, {(tlhd_pkg::TLHD_DIV_STEPS-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= {1'b0, r_den[tlhd_pkg::TLHD_PROD_BITS-1:1]};
            r_quot <= n_quot;
        end
    end

    // quotient is offered on the last step
    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_busy && w_last;
    assign o_rsp.quot = n_quot;

endmodule

### sv/touch_level_hysteresis_detector_unit.sv
// top level of the touch level hysteresis detector: sequencer, state and output register
// depends on tlhd_pkg and tlhd_divider

// Each input transaction is one time tick and gives exactly one output transaction.
// A tick that does not probe (block disabled or probe time not reached) or that
// carries a failed read goes from S_EVAL to S_DONE; a good read whose level needs no
// divide (zero span, no drop, or a drop at or above the span) passes S_EVAL, S_APPLY
// and S_DONE. A probe with a good sample whose drop lies strictly between zero and
// the trigger span runs the shared scaling unit, one 16x10 multiply then a ten-step
// restoring divide with one quotient bit per cycle, and passes S_EVAL, S_DIV,
// S_APPLY and S_DONE. S_DONE waits until the output register is free; the input is
// ready again once the result is loaded, so a new tick is taken only after the last
// one is finished. The result register holds a finished transaction while the
// next tick is accepted and worked on. Configuration is to be written through
// i_cfg_we, i_cfg_addr and i_cfg_wdata while the block is idle; nothing enforces this.

module touch_level_hysteresis_detector_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    // tick input
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // now_ms[47:0], raw_sample[63:48]
    input  logic         i_s_tuser,   // sample_ok
    // result output
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // read_good[0], last_sample[16:1], level[26:17], touch_active[27],
    // touch_rise[28], activation_count[60:29], good_read_count[92:61],
    // bad_read_count[124:93], touch_start_ms[172:125], zero fill[175:173]
    output logic [175:0] o_m_tdata,
    output logic         o_m_tuser    // probed
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int TB = tlhd_pkg::TLHD_TIME_BITS;
    localparam int SB = tlhd_pkg::TLHD_SAMPLE_BITS;
    localparam int LB = tlhd_pkg::TLHD_LEVEL_BITS;
    localparam int CB = tlhd_pkg::TLHD_COUNT_BITS;

    // configuration
    logic          r_enable;
    logic [SB-1:0] r_baseline;
    logic [SB-1:0] r_span;
    logic [15:0]   r_interval;

    // sequencer and latched tick
    logic [2:0]    r_state;
    logic [TB-1:0] r_now;
    logic          r_ok;
    logic [SB-1:0] r_sample;
    logic          r_probe;
    logic [LB-1:0] r_new_level;

    // held state
    logic          r_active;
    logic          r_rise;
    logic          r_last_ok;
    logic [TB-1:0] r_next_probe;
    logic [SB-1:0] r_held_sample;
    logic [LB-1:0] r_held_level;
    logic [TB-1:0] r_edge_time;
    logic [CB-1:0] r_rise_total;
    logic [CB-1:0] r_ok_total;
    logic [CB-1:0] r_fail_total;

    // output register
    logic          r_out_valid;
    logic          r_out_probe;
    logic [172:0]  r_out_data;

    logic                w_accept;
    logic                w_probe;
    logic                w_no_drop;
    logic [SB-1:0]       w_drop;
    logic                w_full;
    logic [TB-1:0]       w_next_time;
    logic                w_new_active;
    logic                w_out_free;
    tlhd_pkg::t_div_req  w_div_req;
    tlhd_pkg::t_div_rsp  w_div_rsp;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // probe decision and drop classification
    assign w_probe     = r_enable && (r_now >= r_next_probe);
    assign w_no_drop   = r_sample >= r_baseline;
    assign w_drop      = r_baseline - r_sample;
    assign w_full      = w_drop >= r_span;
    assign w_next_time = r_now + {{(TB-16){1'b0}}, r_interval};

    // hysteresis on the new level
    assign w_new_active = r_active ? (r_new_level >= tlhd_pkg::TLHD_LEVEL_OFF)
                                   : (r_new_level >= tlhd_pkg::TLHD_LEVEL_ON);

    // shared scaling unit
    assign w_div_req.start = (r_state == S_EVAL) && w_probe && r_ok &&
                             (r_span != '0) && !w_no_drop && !w_full;
    assign w_div_req.drop  = w_drop;
    assign w_div_req.span  = r_span;

    tlhd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_baseline <= '0;
            r_span     <= '0;
            r_interval <= 16'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tlhd_pkg::TLHD_REG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                tlhd_pkg::TLHD_REG_BASELINE: r_baseline <= i_cfg_wdata[SB-1:0];
                tlhd_pkg::TLHD_REG_SPAN:     r_span     <= i_cfg_wdata[SB-1:0];
                tlhd_pkg::TLHD_REG_INTERVAL: r_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // latch the accepted tick
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= i_s_tdata[TB-1:0];
            r_sample <= i_s_tdata[63:48];
            r_ok     <= i_s_tuser;
        end
    end

    // sequencer and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_probe       <= 1'b0;
            r_active      <= 1'b0;
            r_rise        <= 1'b0;
            r_last_ok     <= 1'b0;
            r_next_probe  <= '0;
            r_held_sample <= '0;
            r_held_level  <= '0;
            r_edge_time   <= '0;
            r_rise_total  <= '0;
            r_ok_total    <= '0;
            r_fail_total  <= '0;
            r_new_level   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_probe <= w_probe;
                    if (!w_probe) begin
                        r_state <= S_DONE;
                    end else if (!r_ok) begin
                        // failed read keeps sample, level and touch state
                        r_last_ok    <= 1'b0;
                        r_rise       <= 1'b0;
                        r_fail_total <= r_fail_total + 1'b1;
                        r_next_probe <= w_next_time;
                        r_state      <= S_DONE;
                    end else begin
                        r_held_sample <= r_sample;
                        if (r_span == '0 || w_no_drop) begin
                            r_new_level <= tlhd_pkg::TLHD_LEVEL_ZERO;
                            r_state     <= S_APPLY;
                        end else if (w_full) begin
                            r_new_level <= tlhd_pkg::TLHD_LEVEL_FULL;
                            r_state     <= S_APPLY;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_new_level <= w_div_rsp.quot;
                        r_state     <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_last_ok    <= 1'b1;
                    r_held_level <= r_new_level;
                    r_active     <= w_new_active;
                    r_rise       <= w_new_active && !r_active;
                    if (w_new_active && !r_active) begin
                        r_edge_time  <= r_now;
                        r_rise_total <= r_rise_total + 1'b1;
                    end
                    r_ok_total   <= r_ok_total + 1'b1;
                    r_next_probe <= w_next_time;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_probe <= r_probe;
            r_out_data  <= {r_edge_time, r_fail_total, r_ok_total, r_rise_total,
                            r_rise, r_active, r_held_level, r_held_sample, r_last_ok};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_probe;
    assign o_m_tdata  = {3'b000, r_out_data};

    // checks on the sequencer and held state
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_level <= tlhd_pkg::TLHD_LEVEL_FULL)
        else $error("held level above full scale");

    a_rise_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rise |-> r_active)
        else $error("touch rise without active touch");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted tick not evaluated");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !w_out_free) |=> (r_state == S_DONE))
        else $error("result lost while output register full");

endmodule
